// ===== src/wxvd_pkg.sv =====
package wxvd_pkg;

    localparam int MAX_COLUMNS   = 16;
    localparam int HISTORY_DEPTH = 128;
    localparam int COL_W         = $clog2(MAX_COLUMNS);
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int ADDR_W        = COL_W + SLOT_W;
    localparam int MEM_DEPTH     = MAX_COLUMNS * HISTORY_DEPTH;
    localparam int WORD_W        = 64;
    localparam int CFG_W         = 5;

    localparam logic [3:0]       RAW_BYTES  = 4'd8;
    localparam logic [7:0]       HEAD_RAW   = 8'd255;
    localparam logic [CFG_W-1:0] CFG_MAX    = CFG_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(1);

    typedef logic [WORD_W-1:0] t_word;

    // XOR payload placed above its trailing zero bytes; eight or more gives zero.
    function automatic t_word xor_shift(input t_word acc, input logic [3:0] zero_bytes);
        t_word res;
        if (zero_bytes[3]) begin
            res = '0;
        end else begin
            res = acc << {zero_bytes[2:0], 3'b000};
        end
        return res;
    endfunction

endpackage

// ===== src/window_xor_value_decoder_core.sv =====
// Window XOR value decoder: takes one compressed stream byte per cycle on the input
// channel while input ready is high and delivers each decoded 64-bit word, with its
// column and a row-end flag, on the output channel. The first row after reset is
// eight raw big-endian bytes per column; each column of later rows starts with a head
// byte (window repeat, raw escape, or XOR against a window entry). Sustained rate is
// one byte per cycle while the output is not stalled; a result passes through the
// window stage and then the output register after the byte that completes it is
// taken, because the 128-entry per-column windows live in one 2048 x 64 memory with a
// registered read. A result written back on the same edge that the next byte reads
// that entry is forwarded. Input ready drops only while a result waits in the window
// stage and the output register is full and stalled. The column count register
// (1..16, zero acts as one, larger saturates) is written through the always-ready
// cfg port; the user must do so while the block is idle, which it does not enforce.
module window_xor_value_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wxvd_pkg::CFG_W-1:0]    i_cfg_data,
    // byte stream in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    // decoded values out
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wxvd_pkg::WORD_W-1:0]   o_value_word,
    output logic [3:0]                    o_column_index,
    output logic                          o_row_end
);

    typedef enum logic [2:0] {
        PH_FIRST_RAW,
        PH_HEAD,
        PH_RAW,
        PH_INFO,
        PH_XOR
    } t_phase;

    // decode state (front stage)
    t_phase                            r_phase, n_phase;
    logic [wxvd_pkg::COL_W-1:0]        r_col, n_col;
    logic [3:0]                        r_bytes_left, n_bytes_left;
    wxvd_pkg::t_word                   r_acc, n_acc;
    logic [wxvd_pkg::SLOT_W-1:0]       r_offset, n_offset;
    logic [3:0]                        r_zero, n_zero;
    logic [wxvd_pkg::CFG_W-1:0]        r_cfg;
    logic [wxvd_pkg::SLOT_W-1:0]       r_newest [wxvd_pkg::MAX_COLUMNS];

    // window stage
    logic                              r_s1_valid;
    logic [wxvd_pkg::COL_W-1:0]        r_s1_col;
    logic                              r_s1_last;
    logic                              r_s1_use_read;
    logic [wxvd_pkg::ADDR_W-1:0]       r_s1_waddr;
    wxvd_pkg::t_word                   r_s1_x;
    wxvd_pkg::t_word                   r_rdata;
    logic                              r_fwd_hit;
    wxvd_pkg::t_word                   r_fwd_val;

    // output register
    logic                              r_out_valid;
    wxvd_pkg::t_word                   r_out_word;
    logic [wxvd_pkg::COL_W-1:0]        r_out_col;
    logic                              r_out_last;

    wxvd_pkg::t_word                   mem [wxvd_pkg::MEM_DEPTH];

    // front-stage decode
    logic                              in_fire;
    logic                              s1_adv;
    logic                              fin;
    logic                              fin_read;
    wxvd_pkg::t_word                   fin_x;
    logic [wxvd_pkg::SLOT_W-1:0]       rd_off;
    wxvd_pkg::t_word                   acc_shift;
    logic [3:0]                        bl_dec;
    logic [wxvd_pkg::CFG_W-1:0]        eff_cols;
    logic [wxvd_pkg::CFG_W-1:0]        col_p1;
    logic                              last;
    logic [wxvd_pkg::SLOT_W-1:0]       cur_slot;
    logic [wxvd_pkg::SLOT_W-1:0]       ins_slot;
    logic [wxvd_pkg::ADDR_W-1:0]       raddr;
    logic [wxvd_pkg::ADDR_W-1:0]       waddr;
    wxvd_pkg::t_word                   win_word;
    wxvd_pkg::t_word                   s1_value;

    assign o_cfg_ready = 1'b1;

    // window stage moves when the output register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    assign acc_shift = {r_acc[wxvd_pkg::WORD_W-9:0], i_data_byte};
    assign bl_dec    = (r_bytes_left != 4'd0) ? (r_bytes_left - 4'd1) : 4'd0;

    always_comb begin
        if (r_cfg == '0) begin
            eff_cols = wxvd_pkg::CFG_W'(1);
        end else if (r_cfg > wxvd_pkg::CFG_MAX) begin
            eff_cols = wxvd_pkg::CFG_MAX;
        end else begin
            eff_cols = r_cfg;
        end
    end

    assign col_p1   = wxvd_pkg::CFG_W'(r_col) + wxvd_pkg::CFG_W'(1);
    assign last     = col_p1 >= eff_cols;
    assign cur_slot = r_newest[r_col];
    assign ins_slot = cur_slot + wxvd_pkg::SLOT_W'(1);
    assign raddr    = {r_col, cur_slot - rd_off};
    assign waddr    = {r_col, ins_slot};

    always_comb begin
        n_phase      = r_phase;
        n_col        = r_col;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_offset     = r_offset;
        n_zero       = r_zero;
        fin          = 1'b0;
        fin_read     = 1'b0;
        fin_x        = '0;
        rd_off       = r_offset;

        case (r_phase)
            PH_FIRST_RAW, PH_RAW, PH_XOR: begin
                n_acc        = acc_shift;
                n_bytes_left = bl_dec;
                if (bl_dec == 4'd0) begin
                    fin = 1'b1;
                    if (r_phase == PH_XOR) begin
                        fin_read = 1'b1;
                        fin_x    = wxvd_pkg::xor_shift(acc_shift, r_zero);
                    end else begin
                        fin_x = acc_shift;
                    end
                end
            end
            PH_HEAD: begin
                if (!i_data_byte[7]) begin
                    // window repeat
                    fin      = 1'b1;
                    fin_read = 1'b1;
                    rd_off   = i_data_byte[6:0];
                end else if (i_data_byte == wxvd_pkg::HEAD_RAW) begin
                    n_phase      = PH_RAW;
                    n_bytes_left = wxvd_pkg::RAW_BYTES;
                    n_acc        = '0;
                end else begin
                    n_offset = i_data_byte[6:0];
                    n_phase  = PH_INFO;
                end
            end
            PH_INFO: begin
                n_zero       = i_data_byte[7:4];
                n_bytes_left = i_data_byte[3:0];
                n_acc        = '0;
                if (i_data_byte[3:0] == 4'd0) begin
                    // no XOR bytes: plain copy of the window entry
                    fin      = 1'b1;
                    fin_read = 1'b1;
                end else begin
                    n_phase = PH_XOR;
                end
            end
            default: begin
                n_phase = PH_HEAD;
            end
        endcase

        if (fin) begin
            if (last) begin
                n_col   = '0;
                n_phase = PH_HEAD;
            end else begin
                n_col   = r_col + wxvd_pkg::COL_W'(1);
                n_phase = (r_phase == PH_FIRST_RAW) ? PH_FIRST_RAW : PH_HEAD;
            end
            if (n_phase == PH_FIRST_RAW) begin
                n_bytes_left = wxvd_pkg::RAW_BYTES;
                n_acc        = '0;
            end
        end
    end

    // window stage result
    assign win_word = r_fwd_hit ? r_fwd_val : r_rdata;
    assign s1_value = (r_s1_use_read ? win_word : '0) ^ r_s1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FIRST_RAW;
            r_col         <= '0;
            r_bytes_left  <= wxvd_pkg::RAW_BYTES;
            r_acc         <= '0;
            r_offset      <= '0;
            r_zero        <= '0;
            r_cfg         <= wxvd_pkg::CFG_RESET;
            for (int i = 0; i < wxvd_pkg::MAX_COLUMNS; i++) begin
                r_newest[i] <= '0;
            end
            r_s1_valid    <= 1'b0;
            r_s1_col      <= '0;
            r_s1_last     <= 1'b0;
            r_s1_use_read <= 1'b0;
            r_s1_waddr    <= '0;
            r_s1_x        <= '0;
            r_fwd_hit     <= 1'b0;
            r_fwd_val     <= '0;
            r_out_valid   <= 1'b0;
            r_out_word    <= '0;
            r_out_col     <= '0;
            r_out_last    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end

            if (in_fire) begin
                r_phase      <= n_phase;
                r_col        <= n_col;
                r_bytes_left <= n_bytes_left;
                r_acc        <= n_acc;
                r_offset     <= n_offset;
                r_zero       <= n_zero;
                if (fin) begin
                    r_newest[r_col] <= ins_slot;
                end
            end

            if (in_fire && fin) begin
                r_s1_valid    <= 1'b1;
                r_s1_col      <= r_col;
                r_s1_last     <= last;
                r_s1_use_read <= fin_read;
                r_s1_waddr    <= waddr;
                r_s1_x        <= fin_x;
                // entry being written back this edge: take the new word
                r_fwd_hit     <= s1_adv && (r_s1_waddr == raddr);
                r_fwd_val     <= s1_value;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_out_word  <= s1_value;
                r_out_col   <= r_s1_col;
                r_out_last  <= r_s1_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window memory: registered read when an item issues, write-back as it leaves
    always_ff @(posedge i_clk) begin
        if (in_fire && fin) begin
            r_rdata <= mem[raddr];
        end
        if (s1_adv) begin
            mem[r_s1_waddr] <= s1_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_word   = r_out_word;
    assign o_column_index = 4'(r_out_col);
    assign o_row_end      = r_out_last;

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_first_raw_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST_RAW) |->
            (r_bytes_left != 4'd0 && r_bytes_left <= wxvd_pkg::RAW_BYTES))
        else $error("first-row byte count out of range");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_waddr) && $stable(r_s1_x)))
        else $error("window stage lost a waiting item");

    a_mid_row_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |->
            (r_out_col != wxvd_pkg::COL_W'(wxvd_pkg::MAX_COLUMNS - 1)))
        else $error("top column emitted without row end");

endmodule
